/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication from a trigger to a condition in the same cycle.
`define ASSERT_IMPL(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Clocked implication from a trigger to a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* hdl/dtts_pkg.sv */
// ----------------------------------------------------------------------------
// dtts_pkg
// Types and constants shared by the task table cells and the scheduler top.
// ----------------------------------------------------------------------------
package dtts_pkg;

	localparam int MAX_TASKS_DEF = 16;

	localparam int CB_W    = 8;
	localparam int CTX_W   = 16;
	localparam int DELAY_W = 16;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_RUN    = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CB_W-1:0]    cb;
		logic [CTX_W-1:0]   ctx;
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] reload;
	} entry_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_DECAY  = 2'd1,
		CELL_REMOVE = 2'd2,
		CELL_FIRE   = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [TIME_W-1:0] diff;
		logic [CB_W-1:0]   cb;
		logic [CTX_W-1:0]  ctx;
		logic              use_cb;
		logic              use_ctx;
		logic              ins_en;
		entry_t            ins_entry;
	} cell_ctl_t;

endpackage

/* hdl/dtts_cell.sv */
// ----------------------------------------------------------------------------
// dtts_cell
// One slot of the task table: holds an entry, ages it, and shifts toward
// the head when a hit sits at or in front of it.
// ----------------------------------------------------------------------------
module dtts_cell #(
	parameter int MAX_TASKS = dtts_pkg::MAX_TASKS_DEF,
	parameter int IDX       = 0,
	localparam int CW       = $clog2(MAX_TASKS + 1)
) (
	input  logic               clk,
	input  dtts_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]      count,
	input  logic [CW-1:0]      ins_idx,
	input  dtts_pkg::entry_t   next_entry,
	input  logic               prefix_in,
	output dtts_pkg::entry_t   entry,
	output logic               prefix_out,
	output logic               first
);
	import dtts_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	entry_t entry_q;
	logic   valid;
	logic   match;
	logic   flag;
	logic   take;

	assign valid = MY_IDX < count;
	assign match = (!ctl.use_cb || entry_q.cb == ctl.cb) &&
	               (!ctl.use_ctx || entry_q.ctx == ctl.ctx);
	assign flag  = valid && ((ctl.op == CELL_REMOVE && match) ||
	                         (ctl.op == CELL_FIRE && entry_q.delay == '0));
	assign take       = prefix_in | flag;
	assign prefix_out = take;
	assign first      = flag & ~prefix_in;
	assign entry      = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && ins_idx == MY_IDX) begin
			entry_q <= ctl.ins_entry;
		end else begin
			case (ctl.op)
				CELL_DECAY: begin
					if (valid) begin
						if (ctl.diff[TIME_W-1:DELAY_W] == '0 &&
						    entry_q.delay > ctl.diff[DELAY_W-1:0])
							entry_q.delay <= entry_q.delay - ctl.diff[DELAY_W-1:0];
						else
							entry_q.delay <= '0;
					end
				end
				CELL_REMOVE, CELL_FIRE: begin
					if (take)
						entry_q <= next_entry;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

endmodule

/* hdl/delayed_task_table_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// delayed_task_table_scheduler_unit
// Ordered software-timer task table built as a row of shifting cells.
// ----------------------------------------------------------------------------
// One input transaction gives exactly one result transaction. An add goes
// through ST_ADD, a remove stays in ST_REMOVE while hits remain, and a run
// passes ST_DECAY, ST_FIRE and, when a task fires, ST_RELOAD; all end in
// ST_RESULT. The row of cells deletes one entry per cycle: every cell
// behind the first hit takes its neighbor's entry, so a remove shifts once
// per task removed and firing costs one shift. The input side takes a new
// transaction as soon as the previous one has reached the output register,
// even while that result still waits on m_tready. Only entries below the
// task count are ever read, so the table needs no clearing after reset.
module delayed_task_table_scheduler_unit #(
	parameter int MAX_TASKS = dtts_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] callback_id, [23:8] context_id, [39:24] delay_ms,
	// [55:40] reload_ms, [56] match_callback, [57] match_context,
	// [89:58] now_ms, [95:90] zero
	input  logic [95:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] fired, [8:1] fired_callback, [24:9] fired_context,
	// [25] removed_any, [26] table_full, [31:27] task_count
	output logic [31:0] m_tdata
);
	import dtts_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_REMOVE,
		ST_DECAY,
		ST_FIRE,
		ST_RELOAD,
		ST_RESULT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] last_q;

	// latched input transaction
	entry_t            in_q;
	logic              use_cb_q;
	logic              use_ctx_q;
	logic [TIME_W-1:0] now_q;

	// result flags and fired task
	logic              fired_q;
	logic              removed_q;
	logic              full_q;
	entry_t            fire_q;

	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	cell_ctl_t         ctl;
	entry_t            cell_entry [MAX_TASKS];
	entry_t            nxt_entry  [MAX_TASKS];
	logic [MAX_TASKS:0] chain;
	logic [MAX_TASKS-1:0] first;
	logic              any_hit;
	entry_t            hit_entry;
	logic [TIME_W-1:0] diff;
	logic [CW+4:0]     count_ext;

	assign s_tready  = state_q == ST_IDLE;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign diff      = now_q - last_q;
	assign chain[0]  = 1'b0;
	assign any_hit   = chain[MAX_TASKS];
	assign count_ext = {5'b0, count_q};

	// Drive the row: one operation for all cells plus an optional write at
	// the tail slot, which is always the current count.
	always_comb begin
		ctl         = '0;
		ctl.diff    = diff;
		ctl.cb      = in_q.cb;
		ctl.ctx     = in_q.ctx;
		ctl.use_cb  = use_cb_q;
		ctl.use_ctx = use_ctx_q;
		case (state_q)
			ST_ADD: begin
				ctl.ins_en    = count_q < MAX_CNT;
				ctl.ins_entry = in_q;
			end
			ST_REMOVE: ctl.op = CELL_REMOVE;
			ST_DECAY:  ctl.op = (diff != '0) ? CELL_DECAY : CELL_HOLD;
			ST_FIRE:   ctl.op = CELL_FIRE;
			ST_RELOAD: begin
				ctl.ins_en           = fire_q.reload != '0;
				ctl.ins_entry        = fire_q;
				ctl.ins_entry.delay  = fire_q.reload;
			end
			default:   ctl.op = CELL_HOLD;
		endcase
	end

	// Pick the first ready entry; first is one-hot or empty.
	always_comb begin
		hit_entry = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (first[i])
				hit_entry = hit_entry | cell_entry[i];
		end
	end

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		if (i == MAX_TASKS - 1) begin : g_tail
			assign nxt_entry[i] = '0;
		end else begin : g_body
			assign nxt_entry[i] = cell_entry[i+1];
		end

		dtts_cell #(
			.MAX_TASKS (MAX_TASKS),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.ins_idx    (count_q),
			.next_entry (nxt_entry[i]),
			.prefix_in  (chain[i]),
			.entry      (cell_entry[i]),
			.prefix_out (chain[i+1]),
			.first      (first[i])
		);
	end

	// Hold the fired task for the reload step and the result.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIRE && any_hit)
			fire_q <= hit_entry;
	end

	// Latch the accepted transaction.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_q.cb     <= s_tdata[7:0];
			in_q.ctx    <= s_tdata[23:8];
			in_q.delay  <= s_tdata[39:24];
			in_q.reload <= s_tdata[55:40];
			use_cb_q    <= s_tdata[56];
			use_ctx_q   <= s_tdata[57];
			now_q       <= s_tdata[89:58];
		end
	end

	// Sequencer, table count, last run time and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			last_q     <= '0;
			fired_q    <= 1'b0;
			removed_q  <= 1'b0;
			full_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it now
			if (m_tvalid_q && m_tready && state_q != ST_RESULT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						fired_q   <= 1'b0;
						removed_q <= 1'b0;
						full_q    <= 1'b0;
						case (mode_t'(s_tuser))
							MODE_ADD:    state_q <= ST_ADD;
							MODE_REMOVE: state_q <= ST_REMOVE;
							MODE_RUN:    state_q <= ST_DECAY;
							default:     state_q <= ST_RESULT;
						endcase
					end
				end
				ST_ADD: begin
					if (count_q < MAX_CNT)
						count_q <= count_q + 1'b1;
					else
						full_q <= 1'b1;
					state_q <= ST_RESULT;
				end
				ST_REMOVE: begin
					// drop one hit per cycle until none is left
					if (any_hit) begin
						count_q   <= count_q - 1'b1;
						removed_q <= 1'b1;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_DECAY: begin
					if (diff != '0)
						last_q <= now_q;
					state_q <= ST_FIRE;
				end
				ST_FIRE: begin
					if (any_hit) begin
						count_q <= count_q - 1'b1;
						fired_q <= 1'b1;
						state_q <= ST_RELOAD;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_RELOAD: begin
					if (fire_q.reload != '0)
						count_q <= count_q + 1'b1;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q       <= 1'b1;
						m_tdata_q[0]     <= fired_q;
						m_tdata_q[8:1]   <= fired_q ? fire_q.cb : '0;
						m_tdata_q[24:9]  <= fired_q ? fire_q.ctx : '0;
						m_tdata_q[25]    <= removed_q;
						m_tdata_q[26]    <= full_q;
						m_tdata_q[31:27] <= count_ext[4:0];
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/dtts_checker.sv */
// ----------------------------------------------------------------------------
// dtts_checker
// Port-level checks on the scheduler result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtts_checker #(
	parameter int MAX_TASKS = dtts_pkg::MAX_TASKS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import dtts_pkg::*;

	// a stalled result holds
	`ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result moved")

	// one transaction at a time: the input closes right after acceptance
	`ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

	// count never exceeds the table depth
	`ASSERT_IMPL(a_count, m_tvalid, MAX_TASKS > 31 || m_tdata[31:27] <= MAX_TASKS, "count too big")

	// one outcome flag at most
	`ASSERT_IMPL(a_flags, m_tvalid, $countones(m_tdata[26:25]) + m_tdata[0] <= 2'd1, "flag clash")

	// ids are zero unless a task fired
	`ASSERT_CLK(a_ids, !(m_tvalid && !m_tdata[0]) || m_tdata[24:1] == '0, "ids without a fire")

endmodule

bind delayed_task_table_scheduler_unit dtts_checker #(
	.MAX_TASKS (MAX_TASKS)
) u_dtts_checker (.*);
